// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, disabled while in reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assert that one signal implies another on the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bphf_pkg.sv =====
// ---------------------------------------------------------------------------
// bphf_pkg
// Types and constants for the black pixel hole fill block.
// ---------------------------------------------------------------------------
`default_nettype none
package bphf_pkg;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_FILL  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic [1:0] OFS_ZERO = 2'd0;
  localparam logic [1:0] OFS_DEC  = 2'd1;
  localparam logic [1:0] OFS_INC  = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       read_valid;
  } out_item_t;

  typedef struct packed {
    logic [1:0] dx;
    logic [1:0] dy;
  } nb_ofs_t;

  // Neighbour order: four diagonals, then above/below, then right/left.
  function automatic nb_ofs_t nb_ofs(input logic [2:0] k);
    nb_ofs_t o;
    case (k)
      3'd0: o = '{OFS_DEC, OFS_DEC};
      3'd1: o = '{OFS_INC, OFS_DEC};
      3'd2: o = '{OFS_DEC, OFS_INC};
      3'd3: o = '{OFS_INC, OFS_INC};
      3'd4: o = '{OFS_ZERO, OFS_DEC};
      3'd5: o = '{OFS_ZERO, OFS_INC};
      3'd6: o = '{OFS_INC, OFS_ZERO};
      default: o = '{OFS_DEC, OFS_ZERO};
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/black_pixel_hole_fill.sv =====
// ---------------------------------------------------------------------------
// black_pixel_hole_fill
// RGB frame store with pixel write, pixel read and an in-place fill pass.
// ---------------------------------------------------------------------------
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    in_data (in_item_t)
// out       output     out_valid/out_ready  out_data (out_item_t)
// cfg       input      cfg_we               cfg_index, cfg_data
//
// Write and unknown kinds answer on the cycle after acceptance; a read is
// registered in the memory port (S_RD), then its result is registered.
// Fill pass: each pixel is read in S_CEN/S_CHK; a black pixel then reads up to
// eight neighbours on the single read port (S_NB) and may be written (S_WR).
// One request is in flight at a time; a waiting result blocks input.
// Synchronous reset clears control state; the frame store is not cleared.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module black_pixel_hole_fill #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire bphf_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output bphf_pkg::out_item_t       out_data,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [8:0]           cfg_data
);
  import bphf_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = XW + YW;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_CEN  = 6'b000100,
    S_CHK  = 6'b001000,
    S_NB   = 6'b010000,
    S_WR   = 6'b100000
  } state_t;

  state_t        state;
  logic [8:0]    frame_width;
  logic [8:0]    frame_height;
  logic [WW-1:0] w_cap;
  logic [HW-1:0] h_cap;
  logic [XW-1:0] x;
  logic [YW-1:0] y;
  logic [3:0]    k;
  logic [23:0]   nb [8];
  logic [7:0]    lit;
  logic          inb_q;

  logic          we;
  logic [AW-1:0] waddr;
  logic [23:0]   wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [23:0]   rdata;

  logic          accept;
  logic          in_store;
  logic [XW:0]   xp1;
  logic [YW:0]   yp1;
  logic          x_more;
  logic          y_more;
  nb_ofs_t       ofs;
  logic [XW-1:0] nx;
  logic [YW-1:0] ny;
  logic          inb;
  logic [2:0]    kp;
  logic          mode_diag;
  logic          mode_vert;
  logic          mode_horz;
  logic [23:0]   fill_val;

  bphf_ram #(.AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign w_cap = (32'(frame_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(frame_width);
  assign h_cap = (32'(frame_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(frame_height);

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign in_store = (32'(in_data.col) < MAX_WIDTH) && (32'(in_data.row) < MAX_HEIGHT);

  assign xp1    = (XW+1)'(x) + (XW+1)'(1);
  assign yp1    = (YW+1)'(y) + (YW+1)'(1);
  assign x_more = 32'(xp1) < 32'(w_cap);
  assign y_more = 32'(yp1) < 32'(h_cap);

  assign ofs = nb_ofs(k[2:0]);
  assign kp  = 3'(k - 4'd1);

  always_comb begin
    nx  = x;
    ny  = y;
    inb = 1'b1;
    case (ofs.dx)
      OFS_DEC: begin
        nx  = x - XW'(1);
        inb = inb && (x != '0);
      end
      OFS_INC: begin
        nx  = xp1[XW-1:0];
        inb = inb && x_more;
      end
      default: ;
    endcase
    case (ofs.dy)
      OFS_DEC: begin
        ny  = y - YW'(1);
        inb = inb && (y != '0);
      end
      OFS_INC: begin
        ny  = yp1[YW-1:0];
        inb = inb && y_more;
      end
      default: ;
    endcase
  end

  assign mode_diag = &lit[3:0];
  assign mode_vert = &lit[5:4];
  assign mode_horz = &lit[7:6];

  always_comb begin
    logic [9:0] s4;
    logic [8:0] s2;
    s4       = '0;
    s2       = '0;
    fill_val = '0;
    for (int c = 0; c < 3; c++) begin
      if (mode_diag) begin
        s4 = 10'(nb[0][8*c +: 8]) + 10'(nb[1][8*c +: 8])
           + 10'(nb[2][8*c +: 8]) + 10'(nb[3][8*c +: 8]);
        fill_val[8*c +: 8] = s4[9:2];
      end else if (mode_vert) begin
        s2 = 9'(nb[4][8*c +: 8]) + 9'(nb[5][8*c +: 8]);
        fill_val[8*c +: 8] = s2[8:1];
      end else begin
        s2 = 9'(nb[6][8*c +: 8]) + 9'(nb[7][8*c +: 8]);
        fill_val[8*c +: 8] = s2[8:1];
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = {x, y};
    wdata = fill_val;
    re    = 1'b0;
    raddr = {x, y};
    case (state)
      S_IDLE: begin
        waddr = {XW'(in_data.col), YW'(in_data.row)};
        wdata = {in_data.red_in, in_data.green_in, in_data.blue_in};
        raddr = waddr;
        we    = accept && (in_data.kind == KIND_WRITE) && in_store;
        re    = accept && (in_data.kind == KIND_READ) && in_store;
      end
      S_CEN: re = 1'b1;
      S_NB: begin
        raddr = {nx, ny};
        re    = !k[3] && inb;
      end
      S_WR: we = mode_diag || mode_vert || mode_horz;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 9'd256;
      frame_height <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  frame_width  <= cfg_data;
        CFG_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !accept) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_data.kind)
              KIND_READ: begin
                if (in_store) begin
                  out_valid <= 1'b0;
                  state     <= S_RD;
                end else begin
                  out_data  <= '{red_out: '0, green_out: '0, blue_out: '0,
                                 read_valid: 1'b1};
                  out_valid <= 1'b1;
                end
              end
              KIND_FILL: begin
                x        <= '0;
                y        <= '0;
                out_data <= '0;
                if (w_cap == '0 || h_cap == '0) begin
                  out_valid <= 1'b1;
                end else begin
                  out_valid <= 1'b0;
                  state     <= S_CEN;
                end
              end
              default: begin
                out_data  <= '0;
                out_valid <= 1'b1;
              end
            endcase
          end
        end
        S_RD: begin
          out_data  <= {rdata, 1'b1};
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        S_CEN: state <= S_CHK;
        S_CHK, S_WR: begin
          if (state == S_CHK && rdata == '0) begin
            k     <= '0;
            state <= S_NB;
          end else if (y_more) begin
            y     <= yp1[YW-1:0];
            state <= S_CEN;
          end else if (x_more) begin
            x     <= xp1[XW-1:0];
            y     <= '0;
            state <= S_CEN;
          end else begin
            out_data  <= '0;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_NB: begin
          inb_q <= inb;
          if (k != '0) begin
            nb[kp]  <= rdata;
            lit[kp] <= inb_q && (rdata[23:16] != '0) && (rdata[15:8] != '0)
                       && (rdata[7:0] != '0);
          end
          k <= k + 4'd1;
          if (k[3]) begin
            state <= S_WR;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_ready_idle, clk, rst, !in_ready || state == S_IDLE, "ready outside idle")
  `ASSERT_CLK(a_port_excl, clk, rst, !(we && re), "read and write in one cycle")
  `ASSERT_CLK(a_busy_no_out, clk, rst, state == S_IDLE || !out_valid, "result while busy")
  `ASSERT_NEXT(a_read_done, clk, rst, state == S_RD, out_valid && state == S_IDLE,
               "read result missing")

endmodule
`default_nettype wire

// ===== rtl/bphf_ram.sv =====
// ---------------------------------------------------------------------------
// bphf_ram
// Frame store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module bphf_ram #(
  parameter int AW = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [23:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [23:0]   rdata
);

  logic [23:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for black_pixel_hole_fill: a directed table of
// requests, then random frames of several sizes, checked against table
// results or a predictor with its own copy of the frame store and size.
// ---------------------------------------------------------------------------
module testbench;
  import bphf_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int STORE_H = 256;
  localparam int STORE_W = 256;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    bit         cfg;
    logic       idx;
    logic [8:0] val;
    in_item_t   req;
    bit         typed;
    out_item_t  res;
  } step_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  in_item_t in_data;
  out_item_t out_data;
  logic cfg_we, cfg_index;
  logic [8:0] cfg_data;

  black_pixel_hole_fill dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [23:0] pixels [0:STORE_W*STORE_H-1];
  bit          written [0:STORE_W*STORE_H-1];
  int          cols_used, rows_used;
  out_item_t   pending_reads [$];
  int          mismatches, quiet_cycles;
  bit          idling;
  step_t       steps [$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic bit lit(int x, int y);
    logic [23:0] v;
    if (x < 0 || y < 0 || x >= cols_used || y >= rows_used) return 0;
    v = pixels[x*STORE_H + y];
    return v[23:16] != 0 && v[15:8] != 0 && v[7:0] != 0;
  endfunction

  function automatic logic [23:0] px(int x, int y);
    return pixels[x*STORE_H + y];
  endfunction

  function automatic void fill_holes();
    logic [23:0] a, b, d, e, v;
    int mode;
    for (int x = 0; x < cols_used; x++) begin
      for (int y = 0; y < rows_used; y++) begin
        if (px(x, y) != 0) continue;
        if (lit(x-1, y-1) && lit(x+1, y-1) && lit(x-1, y+1) && lit(x+1, y+1)) mode = 1;
        else if (lit(x, y-1) && lit(x, y+1)) mode = 2;
        else if (lit(x+1, y) && lit(x-1, y)) mode = 3;
        else continue;
        if (mode == 1) begin
          a = px(x-1, y-1); b = px(x+1, y-1); d = px(x-1, y+1); e = px(x+1, y+1);
          for (int c = 0; c < 3; c++)
            v[c*8 +: 8] = 8'((10'(a[c*8 +: 8]) + 10'(b[c*8 +: 8]) + 10'(d[c*8 +: 8])
                              + 10'(e[c*8 +: 8])) >> 2);
        end else begin
          if (mode == 2) begin
            a = px(x, y-1); b = px(x, y+1);
          end else begin
            a = px(x-1, y); b = px(x+1, y);
          end
          for (int c = 0; c < 3; c++)
            v[c*8 +: 8] = 8'((9'(a[c*8 +: 8]) + 9'(b[c*8 +: 8])) >> 1);
        end
        pixels[x*STORE_H + y] = v;
      end
    end
  endfunction

  function automatic out_item_t apply_request(in_item_t r);
    out_item_t o;
    logic [23:0] v;
    o = '0;
    case (r.kind)
      KIND_WRITE: begin
        pixels[r.col*STORE_H + r.row] = {r.red_in, r.green_in, r.blue_in};
        written[r.col*STORE_H + r.row] = 1;
      end
      KIND_FILL: fill_holes();
      KIND_READ: begin
        v = pixels[r.col*STORE_H + r.row];
        o = '{red_out: v[23:16], green_out: v[15:8], blue_out: v[7:0], read_valid: 1'b1};
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic send(in_item_t r, bit typed = 0, out_item_t res = '0);
    out_item_t o;
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    o = apply_request(r);
    pending_reads.push_back(typed ? res : o);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(logic idx, logic [8:0] val);
    int eff;
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    eff = (val > 256) ? 256 : int'(val);
    if (idx == CFG_WIDTH) cols_used = eff;
    else rows_used = eff;
  endtask

  function automatic logic [23:0] rand_pixel();
    logic [23:0] v;
    v = {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
    case ($urandom_range(0, 5))
      0, 1: v = '0;
      2: v[8*$urandom_range(0, 2) +: 8] = '0;
      3: v = 24'($urandom);
      default: ;
    endcase
    return v;
  endfunction

  function automatic in_item_t mk(logic [1:0] k, int x, int y, logic [23:0] v);
    in_item_t r;
    r = '{kind: k, col: x[7:0], row: y[7:0],
          red_in: v[23:16], green_in: v[15:8], blue_in: v[7:0]};
    return r;
  endfunction

  function automatic void add(logic [1:0] k, int x, int y, logic [23:0] v,
                              bit typed = 0, logic [24:0] res = '0);
    steps.push_back('{cfg: 0, idx: 0, val: 0, req: mk(k, x, y, v), typed: typed, res: res});
  endfunction

  function automatic void add_cfg(logic idx, logic [8:0] val);
    steps.push_back('{cfg: 1, idx: idx, val: val, req: '0, typed: 0, res: '0});
  endfunction

  // Results
  initial begin
    int stall;
    out_item_t want;
    out_ready <= 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_reads.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_data);
        end else begin
          want = pending_reads.pop_front();
          if (out_data.red_out !== want.red_out || out_data.green_out !== want.green_out ||
              out_data.blue_out !== want.blue_out ||
              out_data.read_valid !== want.read_valid) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h, got %h", want, out_data);
          end
        end
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[black_pixel_hole_fill] ERROR");
        $finish;
      end
    end
  end

  // Requests
  initial begin
    int dims [7][2] = '{'{511, 1}, '{0, 5}, '{5, 0}, '{3, 3}, '{5, 4}, '{4, 5}, '{6, 3}};
    int x, y;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= 1'b0;
    cfg_data <= '0;
    mismatches = 0;
    idling = 1;
    cols_used = 256;
    rows_used = 256;
    for (int i = 0; i < STORE_W*STORE_H; i++) begin
      pixels[i] = '0;
      written[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add(KIND_WRITE, 0, 0, 24'hffffff, 1, '0);
    add(KIND_WRITE, 255, 255, 24'h0180fe, 1, '0);
    add(KIND_READ, 0, 0, 24'h0, 1, {24'hffffff, 1'b1});
    add(KIND_READ, 255, 255, 24'hffffff, 1, {24'h0180fe, 1'b1});
    add(KIND_NONE, 255, 255, 24'hffffff, 1, '0);
    add(KIND_WRITE, 128, 7, 24'h0, 1, '0);
    add_cfg(CFG_WIDTH, 9'd3);
    add_cfg(CFG_HEIGHT, 9'd3);
    add(KIND_WRITE, 2, 0, 24'h102030);
    add(KIND_WRITE, 0, 2, 24'h304050);
    add(KIND_WRITE, 2, 2, 24'h506070);
    add(KIND_WRITE, 1, 0, 24'h0);
    add(KIND_WRITE, 0, 1, 24'h0);
    add(KIND_WRITE, 1, 1, 24'h0);
    add(KIND_WRITE, 2, 1, 24'h0);
    add(KIND_WRITE, 1, 2, 24'h000509);
    add(KIND_FILL, 0, 0, 24'h0);
    add(KIND_READ, 1, 0, 24'h0);
    add(KIND_READ, 0, 1, 24'h0);
    add(KIND_READ, 1, 1, 24'h0);
    add(KIND_READ, 2, 1, 24'h0);
    add(KIND_READ, 1, 2, 24'h0);
    add_cfg(CFG_WIDTH, 9'd0);
    add(KIND_FILL, 0, 0, 24'h0);
    add(KIND_READ, 1, 1, 24'h0);

    foreach (steps[i]) begin
      if (steps[i].cfg) begin
        set_reg(steps[i].idx, steps[i].val);
      end else begin
        send(steps[i].req, steps[i].typed, steps[i].res);
      end
    end

    foreach (dims[p]) begin
      if (p == 6) idling = 0;
      set_reg(CFG_WIDTH, 9'(dims[p][0]));
      set_reg(CFG_HEIGHT, 9'(dims[p][1]));
      for (int i = 0; i < cols_used; i++)
        for (int j = 0; j < rows_used; j++)
          send(mk(KIND_WRITE, i, j, rand_pixel()));
      for (int n = 0; n < 8; n++) begin
        x = (cols_used > 0) ? $urandom_range(0, cols_used - 1) : 0;
        y = (rows_used > 0) ? $urandom_range(0, rows_used - 1) : 0;
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6: send(mk(KIND_WRITE, x, y, rand_pixel()));
          7, 8: send(mk(KIND_WRITE, $urandom_range(0, 255), $urandom_range(0, 255),
                        rand_pixel()));
          9, 10, 11, 12, 13: begin
            if (!written[x*STORE_H + y]) begin
              x = 255;
              y = 255;
            end
            send(mk(KIND_READ, x, y, 24'($urandom)));
          end
          14: begin
            x = $urandom_range(0, 255);
            y = $urandom_range(0, 255);
            if (!written[x*STORE_H + y]) begin
              x = 0;
              y = 0;
            end
            send(mk(KIND_READ, x, y, 24'($urandom)));
          end
          15, 16: begin
            if (cols_used * rows_used <= 64 || $urandom_range(0, 3) == 0)
              send(mk(KIND_FILL, $urandom_range(0, 255), $urandom_range(0, 255),
                      24'($urandom)));
            else
              send(mk(KIND_READ, 0, 0, 24'($urandom)));
          end
          17: send(mk(KIND_NONE, $urandom_range(0, 255), $urandom_range(0, 255),
                      24'($urandom)));
          default: send(mk(KIND_FILL, 0, 0, 24'h0));
        endcase
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("[black_pixel_hole_fill] OK");
    else
      $display("[black_pixel_hole_fill] ERROR");
    $finish;
  end

endmodule
